[src/bis_pkg.sv]
// Shared types and constants for the binary insertion sorter.
// Used by bis_cell and binary_insertion_sorter_top; depends on nothing.
package bis_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 16;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_SHIFT  = 2'd2;

    typedef struct packed {
        logic   valid;
        logic   gt;
        value_t value;
    } cell_tap_t;

endpackage

[src/binary_insertion_sorter_top.sv]
// Stable ascending sorter for runs of signed values, built as a chain of cells.
// Depends on bis_pkg and bis_cell.
//
// For each input beat, every cell compares its value with the incoming one in
// parallel and the chain opens a gap after any equal values, so a run streams
// in at one beat per cycle. After the beat marked last, the input stalls while
// the run drains from the head cell, one beat per cycle unless out_stall holds
// it, by shifting the chain toward the head. Up to 64 values are held; further
// values of a run are dropped and every output beat of that run carries overflow.
module binary_insertion_sorter_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bis_pkg::value_t value,
    input  logic            last,
    output logic            out_valid,
    input  logic            out_stall,
    output bis_pkg::value_t sorted_value,
    output logic            end_of_run,
    output logic            overflow
);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               in_fire;
    logic               out_fire;
    logic               full;
    bis_pkg::cell_op_t  op;
    bis_pkg::cell_tap_t taps [bis_pkg::DEPTH];

    assign full     = taps[bis_pkg::DEPTH-1].valid;
    assign in_stall = (state_reg == ST_DRAIN);
    assign in_fire  = in_valid && !in_stall;

    assign out_valid    = (state_reg == ST_DRAIN) && taps[0].valid;
    assign out_fire     = out_valid && !out_stall;
    assign sorted_value = taps[0].value;
    assign end_of_run   = !taps[1].valid;
    assign overflow     = dropped_reg;

    always_comb
    begin
        op           = bis_pkg::OP_HOLD;
        state_next   = state_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_fire)
                begin
                    if (full)
                        dropped_next = 1'b1;
                    else
                        op = bis_pkg::OP_INSERT;
                    if (last)
                        state_next = ST_DRAIN;
                end
            end
            default:
            begin
                if (out_fire)
                begin
                    op = bis_pkg::OP_SHIFT;
                    if (end_of_run)
                    begin
                        state_next   = ST_FILL;
                        dropped_next = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < bis_pkg::DEPTH; i++)
        begin : g_cell
            bis_pkg::cell_tap_t left_tap;
            bis_pkg::cell_tap_t right_tap;

            if (i == 0)
            begin : g_head
                assign left_tap.valid = 1'b1;
                assign left_tap.gt    = 1'b0;
                assign left_tap.value = '0;
            end
            else
            begin : g_body
                assign left_tap = taps[i-1];
            end

            if (i == bis_pkg::DEPTH - 1)
            begin : g_tail
                assign right_tap.valid = 1'b0;
                assign right_tap.gt    = 1'b0;
                assign right_tap.value = '0;
            end
            else
            begin : g_inner
                assign right_tap = taps[i+1];
            end

            bis_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (op),
                .new_value (value),
                .left      (left_tap),
                .right     (right_tap),
                .tap       (taps[i])
            );
        end
    endgenerate

endmodule

[src/bis_cell.sv]
// One slot of the insertion chain: holds a value and its valid bit.
// Depends on bis_pkg for the value type, the cell opcodes and the tap struct.
module bis_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  bis_pkg::cell_op_t  op,
    input  bis_pkg::value_t    new_value,
    input  bis_pkg::cell_tap_t left,
    input  bis_pkg::cell_tap_t right,
    output bis_pkg::cell_tap_t tap
);

    logic            valid_reg;
    logic            valid_next;
    bis_pkg::value_t value_reg;
    bis_pkg::value_t value_next;
    logic            gt;

    assign gt = valid_reg && (value_reg > new_value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (op)
            bis_pkg::OP_INSERT:
            begin
                if (left.valid && left.gt)
                begin
                    valid_next = 1'b1;
                    value_next = left.value;
                end
                else if (left.valid && (!valid_reg || gt))
                begin
                    valid_next = 1'b1;
                    value_next = new_value;
                end
            end
            bis_pkg::OP_SHIFT:
            begin
                valid_next = right.valid;
                value_next = right.value;
            end
            default:
            begin
                valid_next = valid_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign tap.valid = valid_reg;
    assign tap.gt    = gt;
    assign tap.value = value_reg;

endmodule
